/* rtl/bta_pkg.sv */
package bta_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NUM_DIGITS = 22;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [1:0] SEL_DEC = 2'd1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;

  typedef enum logic [1:0] {
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PREFIX_ZERO,
    ST_PREFIX_X,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic   clear;
    logic   conv;
    logic   move;
    logic   ser_bit;
    radix_e radix;
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_UA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* rtl/bta_if.sv */
interface bta_in_if;
  logic                             valid;
  logic                             ready;
  logic [bta_pkg::VALUE_W-1:0]      value;
  logic [1:0]                       radix_select;
  logic                             hex_prefix;

  modport source (output valid, value, radix_select, hex_prefix, input ready);
  modport sink   (input valid, value, radix_select, hex_prefix, output ready);
endinterface

interface bta_out_if;
  logic                             valid;
  logic                             ready;
  logic [bta_pkg::CHAR_W-1:0]       text_char;
  logic [bta_pkg::POS_W-1:0]        char_position;
  logic                             is_last;

  modport source (output valid, text_char, char_position, is_last, input ready);
  modport sink   (input valid, text_char, char_position, is_last, output ready);
endinterface

/* rtl/bta_cell.sv */
module bta_cell (
  input  logic                            clk_i,
  input  bta_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            bit_i,
  input  logic [bta_pkg::DIGIT_W-1:0]     lower_i,
  output logic                            carry_o,
  output logic [bta_pkg::DIGIT_W-1:0]     digit_o
);

  logic [bta_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic [bta_pkg::DIGIT_W-1:0] adj;

  // decimal cells correct by three before doubling
  assign adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;

  always_comb begin
    digit_d = digit_q;
    carry_o = 1'b0;
    unique case (ctrl_i.radix)
      bta_pkg::RADIX_OCT: carry_o = digit_q[2];
      bta_pkg::RADIX_DEC: carry_o = adj[3];
      default:            carry_o = digit_q[3];
    endcase
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      unique case (ctrl_i.radix)
        bta_pkg::RADIX_OCT: digit_d = {1'b0, digit_q[1:0], bit_i};
        bta_pkg::RADIX_DEC: digit_d = {adj[2:0], bit_i};
        default:            digit_d = {digit_q[2:0], bit_i};
      endcase
    end else if (ctrl_i.move) begin
      digit_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

/* rtl/bta_ctrl.sv */
module bta_ctrl #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bta_in_if.sink                          in_i,
  bta_out_if.source                       out_o,
  input  logic [bta_pkg::DIGIT_W-1:0]     top_digit_i,
  output bta_pkg::cell_ctrl_t             cell_ctrl_o
);

  localparam int unsigned CntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [bta_pkg::POS_W-1:0] LastIdx = bta_pkg::POS_W'(bta_pkg::NUM_DIGITS - 1);

  bta_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0]           shift_q, shift_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  bta_pkg::radix_e                 radix_q, radix_d;
  logic                            prefix_q, prefix_d;
  logic [bta_pkg::POS_W-1:0]       idx_q, idx_d;
  logic [bta_pkg::POS_W-1:0]       pos_q, pos_d;
  logic                            started_q, started_d;

  logic                            out_valid_q, out_valid_d;
  logic [bta_pkg::CHAR_W-1:0]      char_q, char_d;
  logic [bta_pkg::POS_W-1:0]       opos_q, opos_d;
  logic                            last_q, last_d;

  logic can_emit;
  logic accept;
  logic skip;
  logic load;

  assign can_emit = !out_valid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  // leading zeros are dropped, but the lowest digit always goes out
  assign skip     = !started_q && (top_digit_i == '0) && (idx_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bta_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = bta_pkg::ST_CONVERT;
      end
      bta_pkg::ST_CONVERT: begin
        if (cnt_q == '0) state_d = prefix_q ? bta_pkg::ST_PREFIX_ZERO : bta_pkg::ST_EMIT;
      end
      bta_pkg::ST_PREFIX_ZERO: begin
        if (can_emit) state_d = bta_pkg::ST_PREFIX_X;
      end
      bta_pkg::ST_PREFIX_X: begin
        if (can_emit) state_d = bta_pkg::ST_EMIT;
      end
      bta_pkg::ST_EMIT: begin
        if (!skip && can_emit && idx_q == '0) state_d = bta_pkg::ST_IDLE;
      end
      default: state_d = bta_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready          = 1'b0;
    cell_ctrl_o.clear   = 1'b0;
    cell_ctrl_o.conv    = 1'b0;
    cell_ctrl_o.move    = 1'b0;
    cell_ctrl_o.ser_bit = shift_q[VALUE_BITS-1];
    cell_ctrl_o.radix   = radix_q;
    load                = 1'b0;
    char_d              = char_q;
    opos_d              = opos_q;
    last_d              = last_q;
    unique case (state_q)
      bta_pkg::ST_IDLE: begin
        in_i.ready        = 1'b1;
        cell_ctrl_o.clear = 1'b1;
      end
      bta_pkg::ST_CONVERT: begin
        cell_ctrl_o.conv = 1'b1;
      end
      bta_pkg::ST_PREFIX_ZERO: begin
        load   = can_emit;
        char_d = bta_pkg::CHAR_ZERO;
        opos_d = pos_q;
        last_d = 1'b0;
      end
      bta_pkg::ST_PREFIX_X: begin
        load   = can_emit;
        char_d = bta_pkg::CHAR_X;
        opos_d = pos_q;
        last_d = 1'b0;
      end
      bta_pkg::ST_EMIT: begin
        load             = !skip && can_emit;
        cell_ctrl_o.move = skip || can_emit;
        char_d           = bta_pkg::glyph(top_digit_i);
        opos_d           = pos_q;
        last_d           = (idx_q == '0);
      end
      default: ;
    endcase
    if (!load) begin
      char_d = char_q;
      opos_d = opos_q;
      last_d = last_q;
    end
  end

  // datapath next values
  always_comb begin
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    radix_d     = radix_q;
    prefix_d    = prefix_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    started_d   = started_q;
    out_valid_d = out_o.ready ? 1'b0 : out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      pos_d       = pos_q + 1'b1;
    end
    if (accept) begin
      shift_d = in_i.value[VALUE_BITS-1:0];
      cnt_d   = CntW'(VALUE_BITS - 1);
      if (in_i.radix_select[1]) begin
        radix_d = bta_pkg::RADIX_HEX;
      end else if (in_i.radix_select == bta_pkg::SEL_DEC) begin
        radix_d = bta_pkg::RADIX_DEC;
      end else begin
        radix_d = bta_pkg::RADIX_OCT;
      end
      prefix_d = in_i.hex_prefix && in_i.radix_select[1];
    end
    if (state_q == bta_pkg::ST_CONVERT) begin
      shift_d = shift_q << 1;
      cnt_d   = cnt_q - 1'b1;
      idx_d     = LastIdx;
      pos_d     = '0;
      started_d = 1'b0;
    end
    if (cell_ctrl_o.move) begin
      idx_d = idx_q - 1'b1;
      if (load) started_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bta_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    cnt_q     <= cnt_d;
    radix_q   <= radix_d;
    prefix_q  <= prefix_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    started_q <= started_d;
    char_q    <= char_d;
    opos_q    <= opos_d;
    last_q    <= last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.text_char     = char_q;
  assign out_o.char_position = opos_q;
  assign out_o.is_last       = last_q;

endmodule

/* rtl/binary_to_ascii_radix.sv */
// conversion: after accept, the value is shifted bit-serially into the digit cells, then the
// 22 digit positions are emitted from the most significant down, after a 0x prefix if one
// was requested for hex; leading zero digits are skipped, the lowest digit always goes out
// a new number is accepted only in idle, once the last character has been loaded, and an
// output stall holds the prefix and emit steps
// reset: asynchronous, active low; clears the sequencer and the output valid
module binary_to_ascii_radix #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bta_in_if.sink     in_i,
  bta_out_if.source  out_o
);

  localparam int unsigned NumDigits = bta_pkg::NUM_DIGITS;

  bta_pkg::cell_ctrl_t             cell_ctrl;
  logic [bta_pkg::DIGIT_W-1:0]     digits [NumDigits];
  logic                            carries [NumDigits];

  bta_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .top_digit_i (digits[NumDigits-1]),
    .cell_ctrl_o (cell_ctrl)
  );

  // cell 0 holds the least significant digit; bits enter there and carry upward
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_first
      bta_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl),
        .bit_i   (cell_ctrl.ser_bit),
        .lower_i ('0),
        .carry_o (carries[i]),
        .digit_o (digits[i])
      );
    end else begin : g_rest
      bta_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl),
        .bit_i   (carries[i-1]),
        .lower_i (digits[i-1]),
        .carry_o (carries[i]),
        .digit_o (digits[i])
      );
    end
  end

endmodule
